// File: sv/flhu_pkg.sv
// package for the fault line height grid update block
// types, codes and grid constants shared by every module but flhu_ram; no dependencies
package flhu_pkg;

    localparam int GRID_W    = 8;
    localparam int GRID_EDGE = 1 << GRID_W;
    localparam int IDX_W     = 2 * GRID_W;
    localparam int GRID_SIZE = GRID_EDGE * GRID_EDGE;
    localparam int EDGE_W    = GRID_W + 1;
    localparam int HGT_W     = 8;
    localparam int DIF_W     = 9;
    localparam int PRD_W     = 2 * DIF_W;
    localparam int Z_W       = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [HGT_W-1:0] HGT_MID  = 8'd127;
    localparam logic [HGT_W-1:0] HGT_MAX  = 8'd255;
    localparam logic [HGT_W-1:0] HGT_MIN  = 8'd0;
    localparam logic [EDGE_W-1:0] TILE_RST = EDGE_W'(GRID_EDGE);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_FAULT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [GRID_W-1:0] cell_x;
        logic [GRID_W-1:0] cell_y;
        logic [HGT_W-1:0] cell_value;
        logic [7:0]       fault_x1;
        logic [7:0]       fault_y1;
        logic [7:0]       fault_x2;
        logic [7:0]       fault_y2;
        logic [HGT_W-1:0] fault_depth;
    } t_in_item;

    typedef struct packed {
        logic [HGT_W-1:0] read_height;
        logic [1:0]       done_action;
    } t_out_item;

    typedef struct packed {
        logic             neg;
        logic [HGT_W-1:0] depth;
        logic [HGT_W-1:0] max_h;
        logic [HGT_W-1:0] min_h;
    } t_upd_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FMUL,
        S_FSTART,
        S_FWALK,
        S_FDRAIN,
        S_FINISH
    } t_state;

endpackage

// File: sv/fault_line_heightmap_update.sv
// top level of the fault line height grid update block: control, fault walk, config
// depends on flhu_pkg, flhu_ram, flhu_cell_upd
// write or unused action goes to S_FINISH, read via S_READ, fault via S_FMUL and S_FSTART
// throughput: one item at a time; a fault walks one cell a cycle through the ram port pair
// result register frees the input side while a result waits to be taken
// reset: a clearing pass sets every cell to 127, no item taken meanwhile
// registers reset to max 255, min 0, tile 256
module fault_line_heightmap_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  flhu_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output flhu_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [flhu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [flhu_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    flhu_pkg::t_state r_state, n_state;

    logic [flhu_pkg::IDX_W-1:0]    r_clr, n_clr;
    logic [flhu_pkg::GRID_W-1:0]   r_x, n_x, r_y, n_y;
    logic signed [flhu_pkg::Z_W-1:0]   r_z, n_z, r_zrow, n_zrow;
    logic signed [flhu_pkg::DIF_W-1:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [flhu_pkg::PRD_W-1:0] r_p1, n_p1, r_p2, n_p2;
    logic [7:0]                    r_x1, n_x1, r_y1, n_y1;
    logic [flhu_pkg::HGT_W-1:0]    r_depth, n_depth;
    flhu_pkg::t_out_item           r_res, n_res, r_out, n_out;
    logic                          r_out_valid, n_out_valid;
    logic                          r_wb_valid, n_wb_valid;
    logic [flhu_pkg::IDX_W-1:0]    r_wb_addr, n_wb_addr;
    logic                          r_wb_neg, n_wb_neg;
    logic [flhu_pkg::HGT_W-1:0]    r_max_h, r_min_h;
    logic [flhu_pkg::EDGE_W-1:0]   r_tile;

    logic [flhu_pkg::EDGE_W-1:0]   act_edge;
    logic                          last_y, last_x;
    logic                          in_xfer;
    logic                          ram_we;
    logic [flhu_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [flhu_pkg::HGT_W-1:0]    ram_wdata, ram_rdata;
    flhu_pkg::t_upd_ctl            upd_ctl;
    logic                          upd_we;
    logic [flhu_pkg::HGT_W-1:0]    upd_value;

    flhu_ram #(
        .WIDTH (flhu_pkg::HGT_W),
        .DEPTH (flhu_pkg::GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign upd_ctl = '{neg: r_wb_neg, depth: r_depth, max_h: r_max_h, min_h: r_min_h};

    flhu_cell_upd u_upd (
        .i_height (ram_rdata),
        .i_ctl    (upd_ctl),
        .o_we     (upd_we),
        .o_value  (upd_value)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == flhu_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && o_in_ready;

    assign act_edge = (r_tile > flhu_pkg::TILE_RST) ? flhu_pkg::TILE_RST : r_tile;
    assign last_y   = ({1'b0, r_y} == act_edge - flhu_pkg::EDGE_W'(1));
    assign last_x   = ({1'b0, r_x} == act_edge - flhu_pkg::EDGE_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flhu_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_max_h     <= flhu_pkg::HGT_MAX;
            r_min_h     <= flhu_pkg::HGT_MIN;
            r_tile      <= flhu_pkg::TILE_RST;
        end else begin
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_wb_valid  <= n_wb_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    flhu_pkg::CFG_MAX_HEIGHT: r_max_h <= i_cfg_data[flhu_pkg::HGT_W-1:0];
                    flhu_pkg::CFG_MIN_HEIGHT: r_min_h <= i_cfg_data[flhu_pkg::HGT_W-1:0];
                    flhu_pkg::CFG_TILE_SIZE:  r_tile  <= i_cfg_data[flhu_pkg::EDGE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_zrow    <= n_zrow;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_depth   <= n_depth;
        r_res     <= n_res;
        r_out     <= n_out;
        r_wb_addr <= n_wb_addr;
        r_wb_neg  <= n_wb_neg;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_zrow      = r_zrow;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_depth     = r_depth;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_wb_valid  = 1'b0;
        n_wb_addr   = {r_x, r_y};
        n_wb_neg    = r_z < 0;
        ram_we      = r_wb_valid && upd_we;
        ram_waddr   = r_wb_addr;
        ram_wdata   = upd_value;
        ram_raddr   = {r_x, r_y};

        case (r_state)
            flhu_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = flhu_pkg::HGT_MID;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = flhu_pkg::S_IDLE;
                end
            end
            flhu_pkg::S_IDLE: begin
                ram_raddr = {i_in_data.cell_x, i_in_data.cell_y};
                if (in_xfer) begin
                    n_res   = '{read_height: '0, done_action: i_in_data.action};
                    n_x1    = i_in_data.fault_x1;
                    n_y1    = i_in_data.fault_y1;
                    n_depth = i_in_data.fault_depth;
                    n_dx    = $signed({1'b0, i_in_data.fault_x2})
                            - $signed({1'b0, i_in_data.fault_x1});
                    n_dy    = $signed({1'b0, i_in_data.fault_y2})
                            - $signed({1'b0, i_in_data.fault_y1});
                    case (i_in_data.action)
                        flhu_pkg::ACT_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = {i_in_data.cell_x, i_in_data.cell_y};
                            ram_wdata = i_in_data.cell_value;
                            n_state   = flhu_pkg::S_FINISH;
                        end
                        flhu_pkg::ACT_READ:  n_state = flhu_pkg::S_READ;
                        flhu_pkg::ACT_FAULT: n_state = flhu_pkg::S_FMUL;
                        default:             n_state = flhu_pkg::S_FINISH;
                    endcase
                end
            end
            flhu_pkg::S_READ: begin
                n_res   = '{read_height: ram_rdata, done_action: flhu_pkg::ACT_READ};
                n_state = flhu_pkg::S_FINISH;
            end
            flhu_pkg::S_FMUL: begin
                n_p1    = $signed({1'b0, r_y1}) * r_dx;
                n_p2    = $signed({1'b0, r_x1}) * r_dy;
                n_state = flhu_pkg::S_FSTART;
            end
            flhu_pkg::S_FSTART: begin
                n_zrow  = flhu_pkg::Z_W'(r_p1) - flhu_pkg::Z_W'(r_p2);
                n_z     = flhu_pkg::Z_W'(r_p1) - flhu_pkg::Z_W'(r_p2);
                n_x     = '0;
                n_y     = '0;
                n_state = (act_edge == '0) ? flhu_pkg::S_FINISH : flhu_pkg::S_FWALK;
            end
            flhu_pkg::S_FWALK: begin
                n_wb_valid = 1'b1;
                if (last_y) begin
                    n_y    = '0;
                    n_x    = r_x + 1'b1;
                    n_zrow = r_zrow + flhu_pkg::Z_W'(r_dy);
                    n_z    = r_zrow + flhu_pkg::Z_W'(r_dy);
                    if (last_x) begin
                        n_state = flhu_pkg::S_FDRAIN;
                    end
                end else begin
                    n_y = r_y + 1'b1;
                    n_z = r_z - flhu_pkg::Z_W'(r_dx);
                end
            end
            flhu_pkg::S_FDRAIN: begin
                n_state = flhu_pkg::S_FINISH;
            end
            flhu_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = flhu_pkg::S_IDLE;
                end
            end
            default: n_state = flhu_pkg::S_IDLE;
        endcase
    end

    a_walk_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == flhu_pkg::S_FWALK |-> ({1'b0, r_x} < act_edge && {1'b0, r_y} < act_edge))
        else $error("walk outside active tile");

    a_drain_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == flhu_pkg::S_FDRAIN |-> r_wb_valid)
        else $error("drain without pending write-back");

    a_clear_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == flhu_pkg::S_CLEAR |-> !r_wb_valid && !o_in_ready)
        else $error("activity during clearing pass");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == flhu_pkg::S_FINISH && !r_out_valid) |=> r_out_valid)
        else $error("result not loaded into free output register");

endmodule

// File: sv/flhu_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
module flhu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/flhu_cell_upd.sv
// per cell raise or lower decision of the fault walk, with height limits
// depends on flhu_pkg
module flhu_cell_upd (
    input  logic [flhu_pkg::HGT_W-1:0] i_height,
    input  flhu_pkg::t_upd_ctl         i_ctl,
    output logic                       o_we,
    output logic [flhu_pkg::HGT_W-1:0] o_value
);

    logic [flhu_pkg::HGT_W:0]   sum;
    logic [flhu_pkg::HGT_W+1:0] floor_sum;

    always_comb begin
        sum       = {1'b0, i_height} + {1'b0, i_ctl.depth};
        floor_sum = {2'b00, i_ctl.min_h} + {2'b00, i_ctl.depth};
        if (i_ctl.neg) begin
            o_we    = sum < {1'b0, i_ctl.max_h};
            o_value = sum[flhu_pkg::HGT_W-1:0];
        end else begin
            o_we    = {2'b00, i_height} > floor_sum;
            o_value = i_height - i_ctl.depth;
        end
    end

endmodule

// File: verif/flhu_checker.sv
`timescale 1ns / 100ps
// flhu_checker: watches the item, result and register channels of the height grid block,
// keeps its own copy of the grid and registers, and checks every result transfer in order
// depends on flhu_pkg
module flhu_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  flhu_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  flhu_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [flhu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [flhu_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_due_count
);
    import flhu_pkg::*;

    logic [HGT_W-1:0]  grid_h [0:GRID_SIZE-1];
    logic [HGT_W-1:0]  max_h;
    logic [HGT_W-1:0]  min_h;
    logic [EDGE_W-1:0] tile_n;
    t_out_item         due_results [$];
    int                fails = 0;
    int                results_seen = 0;

    initial begin
        o_fail_count = 0;
        o_due_count  = 0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("%0t flhu_checker: result %0d %s: got %0d, expected %0d",
                 $time, results_seen, what, got, want);
        fails++;
    endtask

    function automatic void walk_fault(input t_in_item it);
        int span;
        int dx;
        int dy;
        int zc;
        int h;
        int dep;
        int x;
        int y;
        span = (int'(tile_n) > GRID_EDGE) ? GRID_EDGE : int'(tile_n);
        dx   = int'(it.fault_x2) - int'(it.fault_x1);
        dy   = int'(it.fault_y2) - int'(it.fault_y1);
        dep  = int'(it.fault_depth);
        for (x = 0; x < span; x++) begin
            for (y = 0; y < span; y++) begin
                h  = int'(grid_h[x * GRID_EDGE + y]);
                zc = (x - int'(it.fault_x1)) * dy - (y - int'(it.fault_y1)) * dx;
                // left of the line rises, right of it and on it sinks
                if (zc < 0) begin
                    if (h + dep < int'(max_h))
                        grid_h[x * GRID_EDGE + y] = HGT_W'(h + dep);
                end else if (h - dep > int'(min_h)) begin
                    grid_h[x * GRID_EDGE + y] = HGT_W'(h - dep);
                end
            end
        end
    endfunction

    function automatic t_out_item grid_step(input t_in_item it);
        t_out_item r;
        r.read_height = '0;
        r.done_action = it.action;
        case (it.action)
            ACT_WRITE: grid_h[{it.cell_x, it.cell_y}] = it.cell_value;
            ACT_READ:  r.read_height = grid_h[{it.cell_x, it.cell_y}];
            ACT_FAULT: walk_fault(it);
            default:   ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (grid_h[k]) grid_h[k] = HGT_MID;
            max_h  = HGT_MAX;
            min_h  = HGT_MIN;
            tile_n = TILE_RST;
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report("with nothing expected", i_out_data.done_action, -1);
                end else begin
                    want = due_results.pop_front();
                    if (i_out_data.read_height !== want.read_height)
                        report("read_height", i_out_data.read_height, want.read_height);
                    if (i_out_data.done_action !== want.done_action)
                        report("done_action", i_out_data.done_action, want.done_action);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_HEIGHT: max_h  = i_cfg_data[HGT_W-1:0];
                    CFG_MIN_HEIGHT: min_h  = i_cfg_data[HGT_W-1:0];
                    CFG_TILE_SIZE:  tile_n = i_cfg_data[EDGE_W-1:0];
                    default:        ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(grid_step(i_in_data));
        end
        o_fail_count <= fails;
        o_due_count  <= due_results.size();
    end

endmodule

// File: verif/tb_fault_line_heightmap_update.sv
`timescale 1ns / 100ps
// tb_fault_line_heightmap_update: drives items and register writes into the height grid block
// with random idling on both sides, and gives the verdict from the count of flhu_checker
// depends on flhu_pkg, flhu_checker and the block's rtl
module tb_fault_line_heightmap_update;
    import flhu_pkg::*;

    localparam real CLK_PERIOD      = 12.0;
    localparam int  RST_CYCLES      = 12;
    localparam int  N_PHASES        = 6;
    localparam int  ITEMS_PER_PHASE = 14;
    localparam int  HOLD_CYCLES     = 400;
    localparam int  WATCH_LIMIT     = 4 * (GRID_SIZE + HOLD_CYCLES);

    localparam logic [1:0]           ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    int fail_count;
    int due_count;
    bit quiet       = 1'b0;
    int hold_req    = 0;
    int idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    fault_line_heightmap_update u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    flhu_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    // no transfer on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("tb_fault_line_heightmap_update: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : rx_side
        int n;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            n = 0;
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 14);
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_in_item cell_item(input logic [1:0] act, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] v);
        t_in_item it;
        it.action      = act;
        it.cell_x      = x;
        it.cell_y      = y;
        it.cell_value  = v;
        it.fault_x1    = 8'($urandom);
        it.fault_y1    = 8'($urandom);
        it.fault_x2    = 8'($urandom);
        it.fault_y2    = 8'($urandom);
        it.fault_depth = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item fault_item(input logic [7:0] x1, input logic [7:0] y1,
                                            input logic [7:0] x2, input logic [7:0] y2,
                                            input logic [7:0] dep);
        t_in_item it;
        it             = cell_item(ACT_FAULT, 8'($urandom), 8'($urandom), 8'($urandom));
        it.fault_x1    = x1;
        it.fault_y1    = y1;
        it.fault_x2    = x2;
        it.fault_y2    = y2;
        it.fault_depth = dep;
        return it;
    endfunction

    // valid stays high after a transfer; the caller offers the next item or drops it
    task automatic send_item(input t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (due_count != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                   p;
        int                   k;
        int                   span;
        int                   reach;
        int                   sel;
        logic [EDGE_W-1:0]    tile_v;
        logic [CFG_DAT_W-1:0] max_v;
        logic [CFG_DAT_W-1:0] min_v;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: corners, unused code, one full-grid fault
        send_item(cell_item(ACT_WRITE, 8'd0, 8'd0, 8'd0));
        send_item(cell_item(ACT_WRITE, 8'd255, 8'd255, 8'd255));
        send_item(cell_item(ACT_WRITE, 8'd255, 8'd0, 8'd200));
        send_item(cell_item(ACT_WRITE, 8'd0, 8'd255, 8'd1));
        send_item(cell_item(ACT_WRITE, 8'd3, 8'd4, 8'd250));
        send_item(cell_item(ACT_READ, 8'd0, 8'd0, 8'd0));
        send_item(cell_item(ACT_READ, 8'd255, 8'd255, 8'd255));
        send_item(cell_item(ACT_UNUSED, 8'd255, 8'd255, 8'd255));
        send_item(cell_item(ACT_READ, 8'd17, 8'd3, 8'd0));
        send_item(fault_item(8'd0, 8'd0, 8'd255, 8'd255, 8'd10));
        send_item(cell_item(ACT_READ, 8'd255, 8'd0, 8'd0));
        send_item(cell_item(ACT_READ, 8'd0, 8'd255, 8'd0));
        send_item(cell_item(ACT_READ, 8'd3, 8'd4, 8'd0));
        send_item(cell_item(ACT_READ, 8'd255, 8'd255, 8'd0));
        i_in_valid <= 1'b0;
        wait_drained();

        // empty tile, spare register index, limits with the top data bit set
        cfg_write(CFG_SPARE, 9'h1FF);
        cfg_write(CFG_TILE_SIZE, 9'h000);
        cfg_write(CFG_MAX_HEIGHT, 9'h1C8);
        cfg_write(CFG_MIN_HEIGHT, 9'h132);
        i_cfg_valid <= 1'b0;
        send_item(fault_item(8'd10, 8'd20, 8'd30, 8'd40, 8'd255));
        send_item(cell_item(ACT_READ, 8'd0, 8'd0, 8'd0));
        i_in_valid <= 1'b0;
        wait_drained();

        // oversized tile clamps to the grid; degenerate line lowers every cell that stays above the minimum
        cfg_write(CFG_TILE_SIZE, 9'h1FF);
        cfg_write(CFG_MAX_HEIGHT, 9'h0FF);
        cfg_write(CFG_MIN_HEIGHT, 9'h000);
        i_cfg_valid <= 1'b0;
        send_item(fault_item(8'd200, 8'd7, 8'd200, 8'd7, 8'd1));
        send_item(cell_item(ACT_READ, 8'd255, 8'd255, 8'd0));
        send_item(cell_item(ACT_READ, 8'd0, 8'd0, 8'd0));
        send_item(cell_item(ACT_READ, 8'd3, 8'd4, 8'd0));
        i_in_valid <= 1'b0;
        wait_drained();

        for (p = 0; p < N_PHASES; p++) begin
            quiet  = (p == N_PHASES - 1);
            tile_v = ($urandom_range(0, 5) == 0) ? 9'd0 : 9'($urandom_range(1, 16));
            if (p == 1) begin
                max_v = 9'h100;
                min_v = 9'h0FF;
            end else begin
                max_v = {1'($urandom), 8'($urandom_range(150, 255))};
                min_v = {1'($urandom), 8'($urandom_range(0, 100))};
            end
            cfg_write(CFG_TILE_SIZE, tile_v);
            cfg_write(CFG_MAX_HEIGHT, max_v);
            cfg_write(CFG_MIN_HEIGHT, min_v);
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_SPARE, 9'($urandom));
            i_cfg_valid <= 1'b0;
            if (p == 2)
                hold_req = HOLD_CYCLES;
            span = (tile_v == 0) ? 1 : int'(tile_v);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                sel   = $urandom_range(0, 19);
                reach = ($urandom_range(0, 3) == 0) ? 255 : span - 1;
                if (sel < 6) begin
                    send_item(cell_item(ACT_WRITE, 8'($urandom_range(0, reach)),
                                        8'($urandom_range(0, reach)), 8'($urandom)));
                end else if (sel < 12) begin
                    send_item(cell_item(ACT_READ, 8'($urandom_range(0, reach)),
                                        8'($urandom_range(0, reach)), 8'($urandom)));
                end else if (sel < 19) begin
                    reach = (reach == 255) ? 255 : span + 1;
                    send_item(fault_item(8'($urandom_range(0, reach)),
                                         8'($urandom_range(0, reach)),
                                         8'($urandom_range(0, reach)),
                                         8'($urandom_range(0, reach)),
                                         ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                     : 8'($urandom_range(0, 40))));
                end else begin
                    send_item(cell_item(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom)));
                end
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0)
            $display("tb_fault_line_heightmap_update: clean");
        else
            $display("tb_fault_line_heightmap_update: errors");
        $finish;
    end

endmodule
